@@ rtl/core/sact_pkg.sv @@
// Shared types, status codes and defaults for the sorted access code table.
`timescale 1ns / 1ps
package sact_pkg;

  // Default table depth
  localparam int unsigned DEF_CAPACITY = 256;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_GRANTED   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  // Item kinds
  localparam logic KIND_INSERT   = 1'b0;
  localparam logic KIND_VALIDATE = 1'b1;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ACT
  } state_e;

  // One stored table entry
  typedef struct packed {
    logic [31:0] code;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } entry_t;

  // Accepted input item, held for the whole operation
  typedef struct packed {
    logic        kind;
    logic [31:0] code;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] now_time;
  } item_t;

  // Per-cell compare results
  typedef struct packed {
    logic lt;     // stored code below the key
    logic eq;     // stored code equals the key
    logic grant;  // equal and now_time inside the window
  } cell_flag_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic cmp;  // register compare flags
    logic ins;  // shift up and insert
  } cell_ctrl_t;

endpackage

@@ rtl/core/sorted_access_code_table.sv @@
// Top level of the sorted access code table: item handshake, sequencer, cell chain.
`timescale 1ns / 1ps
// The table keeps up to CAPACITY access codes in ascending order in a chain of
// cells, one entry per cell. An insert item (tuser 0) places its code and
// window at the sorted position, answering inserted, duplicate or table full;
// a validate item (tuser 1) answers granted, outside window or not found. Every
// item gives exactly one result. An item is first registered, then every
// cell compares its entry with the key in parallel, then the cell flags are
// combined and, for an insert, the cells above the insert point shift up by
// one in the same cycle. The next item is taken only when the sequencer is
// idle again and the result register is empty or being read.
// The table needs no clearing after reset: the fill count starts at zero.
module sorted_access_code_table #(
  parameter int unsigned CAPACITY = sact_pkg::DEF_CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: code[31:0], start_time[63:32], end_time[95:64], now_time[127:96]
  input  logic [127:0] s_axis_tdata,
  // tuser: kind[0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: status[2:0], entry_count[11:3], zero[15:12]
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready
);
  import sact_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e           state_q, state_d;
  item_t            item_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       status_q, status_d;
  logic [8:0]       ecount_q, ecount_d;
  cell_ctrl_t       ctrl;
  logic             accept;
  logic             any_eq, any_grant, full;
  logic [31:0]      count_ext;

  entry_t     entries [CAPACITY];
  cell_flag_t flags   [CAPACITY];
  logic [CAPACITY-1:0] eq_vec, grant_vec;
  entry_t     first_prev;

  // Take an item when idle and the result register is free
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind       <= s_axis_tuser;
      item_q.code       <= s_axis_tdata[31:0];
      item_q.start_time <= s_axis_tdata[63:32];
      item_q.end_time   <= s_axis_tdata[95:64];
      item_q.now_time   <= s_axis_tdata[127:96];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_ACT;
      S_ACT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Combine the cell flags
  assign first_prev.code       = item_q.code;
  assign first_prev.start_time = item_q.start_time;
  assign first_prev.end_time   = item_q.end_time;

  assign any_eq    = |eq_vec;
  assign any_grant = |grant_vec;
  assign full      = count_q == CNT_W'(CAPACITY);

  // Cell commands, result and count update
  always_comb begin
    ctrl        = '0;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: ;
      S_CMP:  ctrl.cmp = 1'b1;
      S_ACT: begin
        out_valid_d = 1'b1;
        if (item_q.kind == KIND_INSERT) begin
          if (full) begin
            status_d = ST_FULL;
          end else if (any_eq) begin
            status_d = ST_DUPLICATE;
          end else begin
            status_d = ST_INSERTED;
            ctrl.ins = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end else begin
          if (!any_eq) begin
            status_d = ST_NOT_FOUND;
          end else if (any_grant) begin
            status_d = ST_GRANTED;
          end else begin
            status_d = ST_OUTSIDE;
          end
        end
      end
      default: ;
    endcase
  end

  assign count_ext = 32'(count_d);
  assign ecount_d  = count_ext[8:0];

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACT) begin
      status_q <= status_d;
      ecount_q <= ecount_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, ecount_q, status_q};

  // Cell chain: each cell sees its lower neighbor's entry and flag
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_entry;
    logic   prev_lt;
    if (i == 0) begin : g_first
      assign prev_entry = first_prev;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
      assign prev_lt    = flags[i-1].lt;
    end
    sact_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (item_q),
      .count_i      (count_q),
      .prev_entry_i (prev_entry),
      .prev_lt_i    (prev_lt),
      .entry_o      (entries[i]),
      .flags_o      (flags[i])
    );
    assign eq_vec[i]    = flags[i].eq;
    assign grant_vec[i] = flags[i].grant;
  end

endmodule

@@ rtl/core/sact_cell.sv @@
// One table cell: holds an entry, compares it to the key, shifts on insert.
`timescale 1ns / 1ps
module sact_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sact_pkg::cell_ctrl_t ctrl_i,
  input  sact_pkg::item_t     key_i,
  input  logic [CNT_W-1:0]    count_i,
  input  sact_pkg::entry_t    prev_entry_i,
  input  logic                prev_lt_i,
  output sact_pkg::entry_t    entry_o,
  output sact_pkg::cell_flag_t flags_o
);
  import sact_pkg::*;

  entry_t     entry_q;
  cell_flag_t flags_q;
  cell_flag_t flags_d;
  entry_t     new_entry;
  logic       in_use;

  // Occupied when this cell sits below the fill count
  assign in_use = CNT_W'(IDX) < count_i;

  assign new_entry.code       = key_i.code;
  assign new_entry.start_time = key_i.start_time;
  assign new_entry.end_time   = key_i.end_time;

  // Compare the stored entry against the broadcast key
  always_comb begin
    flags_d.lt    = in_use && (entry_q.code < key_i.code);
    flags_d.eq    = in_use && (entry_q.code == key_i.code);
    flags_d.grant = flags_d.eq &&
                    (key_i.now_time >= entry_q.start_time) &&
                    (key_i.now_time <= entry_q.end_time);
  end

  // Hold the compare flags for the neighbor and the combine step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.cmp) begin
      flags_q <= flags_d;
    end
  end

  // Keep smaller entries, take the new item at the boundary, shift the rest up
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !flags_q.lt) begin
      entry_q <= prev_lt_i ? new_entry : prev_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;

endmodule

@@ verif/sact_table_checker.sv @@
// Checker for the sorted access code table: watches both streams, predicts and compares results.
`timescale 1ns / 1ps
module sact_table_checker #(
  parameter int unsigned CAPACITY = sact_pkg::DEF_CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: code[31:0], start_time[63:32], end_time[95:64], now_time[127:96]
  input  logic [127:0] s_axis_tdata,
  // tuser: kind[0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // tdata: status[2:0], entry_count[11:3], zero[15:12]
  input  logic [15:0]  m_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output int           error_count_o,
  output int           pending_o,
  output int           checked_o
);
  import sact_pkg::*;

  // Maximum number of mismatch lines printed; all are counted
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] entry_count;
  } reply_t;

  // Shadow copy of the table contents, kept sorted by code
  logic [31:0] code_mem [CAPACITY];
  logic [31:0] from_mem [CAPACITY];
  logic [31:0] until_mem[CAPACITY];
  int unsigned fill;

  reply_t replies_due[$];
  item_t  item_in;
  reply_t want;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    checked_o     = 0;
    fill          = 0;
  end

  task automatic report_mismatch(input string msg);
    error_count_o++;
    if (error_count_o <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Apply one item to the shadow table and return the reply it should produce
  function automatic reply_t apply_table_item(input item_t it);
    int unsigned pos;
    int unsigned k;
    logic        hit;
    reply_t      r;
    pos = 0;
    while (pos < fill && code_mem[pos] < it.code) pos++;
    hit = (pos < fill) && (code_mem[pos] == it.code);
    if (it.kind == KIND_INSERT) begin
      if (fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (hit) begin
        r.status = ST_DUPLICATE;
      end else begin
        // shift the larger entries up and drop the new one in its place
        for (k = fill; k > pos; k--) begin
          code_mem[k]  = code_mem[k-1];
          from_mem[k]  = from_mem[k-1];
          until_mem[k] = until_mem[k-1];
        end
        code_mem[pos]  = it.code;
        from_mem[pos]  = it.start_time;
        until_mem[pos] = it.end_time;
        fill++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (!hit) begin
        r.status = ST_NOT_FOUND;
      end else if (it.now_time >= from_mem[pos] && it.now_time <= until_mem[pos]) begin
        r.status = ST_GRANTED;
      end else begin
        r.status = ST_OUTSIDE;
      end
    end
    r.entry_count = 9'(fill);
    return r;
  endfunction

  // Compare results first, then queue the prediction for a newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      replies_due.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result %h with no item outstanding", m_axis_tdata));
        end else begin
          want = replies_due.pop_front();
          checked_o++;
          if (m_axis_tdata[2:0] !== want.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      m_axis_tdata[2:0], want.status));
          end
          if (m_axis_tdata[11:3] !== want.entry_count) begin
            report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                      m_axis_tdata[11:3], want.entry_count));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_in.kind       = s_axis_tuser;
        item_in.code       = s_axis_tdata[31:0];
        item_in.start_time = s_axis_tdata[63:32];
        item_in.end_time   = s_axis_tdata[95:64];
        item_in.now_time   = s_axis_tdata[127:96];
        replies_due.push_back(apply_table_item(item_in));
      end
      pending_o <= replies_due.size();
    end
  end

endmodule

@@ verif/tb_sorted_access_code_table.sv @@
// Testbench top for the sorted access code table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_sorted_access_code_table;
  import sact_pkg::*;

  localparam int unsigned CAPACITY   = DEF_CAPACITY;
  localparam int          PHASE_LEN  = 250;
  localparam int          SETTLE_CYC = 20;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic [127:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int          error_count;
  int          pending;
  int          checked;
  int          n_insert      = 0;
  int          n_validate    = 0;

  // Codes and windows the table should hold, used to aim lookups
  logic [31:0] pool_code[$];
  logic [31:0] pool_from[$];
  logic [31:0] pool_until[$];

  sorted_access_code_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  sact_table_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .error_count_o(error_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stall the result stream at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pool_find(input logic [31:0] code);
    foreach (pool_code[i]) begin
      if (pool_code[i] == code) return i;
    end
    return -1;
  endfunction

  function automatic logic [31:0] fresh_code();
    logic [31:0] c;
    do c = $urandom; while (pool_find(c) >= 0);
    return c;
  endfunction

  // Present one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic kind, input logic [31:0] code, input logic [31:0] from,
                           input logic [31:0] to_time, input logic [31:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {now, to_time, from, code};
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_INSERT) begin
      n_insert++;
      if (pool_find(code) < 0 && pool_code.size() < CAPACITY) begin
        pool_code.push_back(code);
        pool_from.push_back(from);
        pool_until.push_back(to_time);
      end
    end else begin
      n_validate++;
    end
  endtask

  task automatic send_insert(input logic [31:0] code, input logic [31:0] from,
                             input logic [31:0] to_time);
    send_item(KIND_INSERT, code, from, to_time, $urandom);
  endtask

  task automatic send_validate(input logic [31:0] code, input logic [31:0] now);
    send_item(KIND_VALIDATE, code, $urandom, $urandom, now);
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_all_replied();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // One random item: mostly fresh inserts and lookups aimed at window edges
  task automatic random_item(input int unsigned insert_pct);
    logic [31:0] code;
    logic [31:0] from;
    logic [31:0] to_time;
    logic [31:0] span;
    logic [31:0] now;
    int          idx;
    if ($urandom_range(99) < insert_pct) begin
      if (pool_code.size() != 0 && $urandom_range(99) < 15) begin
        code = pool_code[$urandom_range(pool_code.size() - 1)];
      end else begin
        code = fresh_code();
      end
      case ($urandom_range(9))
        0: begin
          from    = '0;
          to_time = '1;
        end
        1: begin
          to_time = $urandom_range(32'h7fff_ffff);
          from    = to_time + 1 + $urandom_range(1000);
        end
        2: begin
          from    = $urandom;
          to_time = from;
        end
        default: begin
          from    = $urandom;
          span    = $urandom_range(100000);
          to_time = (from > 32'hffff_ffff - span) ? 32'hffff_ffff : from + span;
        end
      endcase
      send_insert(code, from, to_time);
    end else if (pool_code.size() != 0 && $urandom_range(99) < 75) begin
      idx     = $urandom_range(pool_code.size() - 1);
      from    = pool_from[idx];
      to_time = pool_until[idx];
      case ($urandom_range(5))
        0: now = from - 1;
        1: now = from;
        2: now = to_time;
        3: now = to_time + 1;
        4: now = (from <= to_time) ? from + $urandom_range(to_time - from) : $urandom;
        default: now = $urandom;
      endcase
      send_validate(pool_code[idx], now);
    end else begin
      send_validate($urandom, $urandom);
    end
  endtask

  initial begin
    src_idle_pct  = 9;
    sink_idle_pct = 55;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, both ends of the code range, insert ahead of the
    // last entry, duplicate keeping its window, window edges, inverted window
    send_validate(32'h0000_0000, 32'h0);
    send_insert(32'h8000_0000, 32'd100, 32'd200);
    send_insert(32'hffff_ffff, 32'd5, 32'd5);
    send_insert(32'h0000_0000, 32'h0, 32'hffff_ffff);
    send_insert(32'h4000_0000, 32'h0, 32'h0);
    send_insert(32'h8000_0001, 32'd1000, 32'd999);
    send_insert(32'h8000_0000, 32'd7, 32'd9);
    send_validate(32'h8000_0000, 32'd99);
    send_validate(32'h8000_0000, 32'd100);
    send_validate(32'h8000_0000, 32'd200);
    send_validate(32'h8000_0000, 32'd201);
    send_validate(32'h8000_0000, 32'd8);
    send_validate(32'hffff_ffff, 32'd5);
    send_validate(32'hffff_ffff, 32'd4);
    send_validate(32'hffff_ffff, 32'd6);
    send_validate(32'h0000_0000, 32'h0);
    send_validate(32'h0000_0000, 32'hffff_ffff);
    send_validate(32'h8000_0001, 32'd999);
    send_validate(32'h8000_0001, 32'd1000);
    send_validate(32'h7fff_ffff, 32'd150);
    send_validate(32'h4000_0000, 32'h0);
    send_validate(32'h4000_0000, 32'h1);
    send_insert(32'h0000_0001, 32'd2, 32'd3);
    send_validate(32'h0000_0001, 32'd3);

    // Phase one: insert-heavy, receiver stalls often
    for (int n = 0; n < PHASE_LEN; n++) random_item(70);
    s_axis_tvalid <= 1'b0;
    wait_all_replied();

    // Phase two: sender idles often
    src_idle_pct  = 55;
    sink_idle_pct = 9;
    for (int n = 0; n < PHASE_LEN; n++) random_item(50);
    s_axis_tvalid <= 1'b0;
    wait_all_replied();

    // Phase three: full rate, top the table up, then hit it while full
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (int n = 0; n < PHASE_LEN; n++) begin
      if (pool_code.size() < CAPACITY) begin
        send_insert(fresh_code(), $urandom, $urandom);
      end else begin
        random_item(40);
      end
    end
    send_insert(pool_code[0], pool_from[0], pool_until[0]);
    send_insert(fresh_code(), $urandom, $urandom);
    s_axis_tvalid <= 1'b0;

    wait_all_replied();
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Covered %0d insert and %0d validate items; table reached %0d of %0d entries.",
             n_insert, n_validate, pool_code.size(), CAPACITY);
    $display("Checked %0d results over three pacing phases with %0d mismatches.",
             checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
